/* rtl/core/gtp_pkg.sv */
package gtp_pkg;

    // Default coordinate width and register reset values
    localparam int COORD_BITS_DEF = 12;
    localparam int WIDTH_RESET    = 480;
    localparam int HEIGHT_RESET   = 360;

    // Color ring modulus
    localparam int COLOR_MOD = 255;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // APB port widths
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Input width of the mod-255 reduction
    localparam int MOD_IN_W = 32;

    // Register index codes (byte address bit 2)
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    // Reduce a value mod 255 by folding bytes (256 == 1 mod 255)
    function automatic logic [7:0] mod255(input logic [MOD_IN_W-1:0] v);
        logic [9:0] s;
        logic [8:0] t;
        s = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[31:24]);
        t = 9'(s[7:0]) + 9'(s[9:8]);
        if (t >= 9'(COLOR_MOD))
        begin
            t = t - 9'(COLOR_MOD);
        end
        return t[7:0];
    endfunction

    // (a + b) mod 255 for a below 255 and b up to 255
    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] t;
        t = 9'(a) + 9'(b);
        if (t >= 9'(COLOR_MOD))
        begin
            t = t - 9'(COLOR_MOD);
        end
        return t[7:0];
    endfunction

endpackage

/* rtl/core/gradient_test_pattern_gen.sv */
// Animated RGB gradient test pattern source. Every transfer on the input
// channel with pixel_request set yields the next pixel in raster order with
// its column, row and line/frame end flags; red runs across the line, green
// down the frame, blue is 255 minus green, and the pattern shifts by one step
// per frame. A transfer with pixel_request clear is taken and yields nothing.
// image_width (address 0x0) and image_height (address 0x4) are set over the
// APB port, reset to 480 and 360; zero acts as one. Write them only while no
// pixel is in flight. In the back end, bit-serial dividers scale column and
// row to the 0..254 gradient, one quotient bit per cycle. A two-entry queue
// ahead of the dividers and a result register behind them let requests be
// taken while a finished pixel waits on the output.
module gradient_test_pattern_gen #(
    parameter int COORD_BITS = gtp_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            pixel_request,
    // pixel channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic [COORD_BITS-1:0]           column,
    output logic [COORD_BITS-1:0]           row,
    output logic                            end_of_line,
    output logic                            end_of_frame,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gtp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gtp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gtp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int ITEM_W = 4*COORD_BITS + 10;

    logic [COORD_BITS-1:0] width_reg, width_next;
    logic [COORD_BITS-1:0] height_reg, height_next;
    gtp_pkg::reg_idx_t     reg_idx;
    logic                  cfg_write;
    logic                  push, pop, queue_full, queue_empty;
    logic [ITEM_W-1:0]     push_data, pop_data;

    // register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = gtp_pkg::reg_idx_t'(paddr[gtp_pkg::APB_ADDR_W-1]);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        prdata      = '0;
        unique case (reg_idx)
            gtp_pkg::REG_IMAGE_WIDTH:
            begin
                prdata = gtp_pkg::APB_DATA_W'(width_reg);
                if (cfg_write)
                begin
                    width_next = pwdata[COORD_BITS-1:0];
                end
            end
            gtp_pkg::REG_IMAGE_HEIGHT:
            begin
                prdata = gtp_pkg::APB_DATA_W'(height_reg);
                if (cfg_write)
                begin
                    height_next = pwdata[COORD_BITS-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= COORD_BITS'(gtp_pkg::WIDTH_RESET);
            height_reg <= COORD_BITS'(gtp_pkg::HEIGHT_RESET);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // front: takes requests, tracks raster position and phase
    gtp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_request (pixel_request),
        .image_width   (width_reg),
        .image_height  (height_reg),
        .queue_full    (queue_full),
        .push          (push),
        .push_data     (push_data)
    );

    // queue between front and back
    gtp_fifo #(
        .DATA_W (ITEM_W),
        .DEPTH  (gtp_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // back: divides, reduces mod 255 and registers the pixel
    gtp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .pop_data     (pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .column       (column),
        .row          (row),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );

endmodule

/* rtl/core/gtp_front.sv */
module gtp_front #(
    parameter int COORD_BITS = gtp_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          pixel_request,
    input  logic [COORD_BITS-1:0]         image_width,
    input  logic [COORD_BITS-1:0]         image_height,
    input  logic                          queue_full,
    output logic                          push,
    output logic [4*COORD_BITS+10-1:0]    push_data
);

    localparam int ITEM_W = 4*COORD_BITS + 10;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
        logic [7:0]            phase;
        logic                  eol;
        logic                  eof;
    } item_t;

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [7:0]            phase_reg, phase_next;
    logic [COORD_BITS-1:0] w_eff, h_eff;
    logic                  eol, eof, accept;
    item_t                 item;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    // a request of zero is taken but makes no pixel
    assign push     = accept && pixel_request;

    // zero size acts as one
    assign w_eff = (image_width == '0) ? COORD_BITS'(1) : image_width;
    assign h_eff = (image_height == '0) ? COORD_BITS'(1) : image_height;

    // line and frame ends, also when a counter is past a shrunk size
    assign eol = ({1'b0, col_reg} + (COORD_BITS+1)'(1)) >= {1'b0, w_eff};
    assign eof = eol && (({1'b0, row_reg} + (COORD_BITS+1)'(1)) >= {1'b0, h_eff});

    always_comb
    begin
        item.col    = col_reg;
        item.row    = row_reg;
        item.width  = w_eff;
        item.height = h_eff;
        item.phase  = phase_reg;
        item.eol    = eol;
        item.eof    = eof;
    end

    assign push_data = ITEM_W'(item);

    // raster position and frame phase
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        if (push)
        begin
            if (eol)
            begin
                col_next = '0;
                if (eof)
                begin
                    row_next   = '0;
                    phase_next = (phase_reg == 8'(gtp_pkg::COLOR_MOD - 1)) ? 8'd0
                                                                          : phase_reg + 8'd1;
                end
                else
                begin
                    row_next = row_reg + COORD_BITS'(1);
                end
            end
            else
            begin
                col_next = col_reg + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
        end
    end

endmodule

/* rtl/core/gtp_fifo.sv */
module gtp_fifo #(
    parameter int DATA_W = 58,
    parameter int DEPTH  = gtp_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/gtp_div.sv */
module gtp_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   rem_sh, diff;
    logic             ge;

    // one restoring step: shift in next dividend bit, try to subtract
    assign rem_sh = {rem_reg, q_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    assign busy = busy_reg;
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            q_reg    <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/gtp_back.sv */
module gtp_back #(
    parameter int COORD_BITS = gtp_pkg::COORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       queue_empty,
    output logic                       pop,
    input  logic [4*COORD_BITS+10-1:0] pop_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 red,
    output logic [7:0]                 green,
    output logic [7:0]                 blue,
    output logic [COORD_BITS-1:0]      column,
    output logic [COORD_BITS-1:0]      row,
    output logic                       end_of_line,
    output logic                       end_of_frame
);

    localparam int NUM_W = COORD_BITS + 8;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
        logic [7:0]            phase;
        logic                  eol;
        logic                  eof;
    } item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    item_t                 item;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [7:0]            phase_reg, phase_next;
    logic                  eol_reg, eol_next;
    logic                  eof_reg, eof_next;
    logic [7:0]            rx_reg, rx_next;
    logic [7:0]            gx_reg, gx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            red_reg, red_next;
    logic [7:0]            green_reg, green_next;
    logic [7:0]            blue_reg, blue_next;
    logic [COORD_BITS-1:0] column_reg, column_next;
    logic [COORD_BITS-1:0] row_out_reg, row_out_next;
    logic                  eol_out_reg, eol_out_next;
    logic                  eof_out_reg, eof_out_next;
    logic [NUM_W-1:0]      num_x, num_y, quot_x, quot_y;
    logic                  busy_x, busy_y;
    logic [7:0]            green_val;

    assign item = item_t'(pop_data);
    assign pop  = (state_reg == S_IDLE) && !queue_empty;

    // col*255 and row*255 as shift and subtract
    assign num_x = (NUM_W'(item.col) << 8) - NUM_W'(item.col);
    assign num_y = (NUM_W'(item.row) << 8) - NUM_W'(item.row);

    // bit-serial dividers for both gradients
    gtp_div #(
        .NUM_W (NUM_W),
        .DEN_W (COORD_BITS)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pop),
        .num   (num_x),
        .den   (item.width),
        .busy  (busy_x),
        .quot  (quot_x)
    );

    gtp_div #(
        .NUM_W (NUM_W),
        .DEN_W (COORD_BITS)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pop),
        .num   (num_y),
        .den   (item.height),
        .busy  (busy_y),
        .quot  (quot_y)
    );

    // final color from reduced quotients
    assign green_val = gtp_pkg::add_mod255(gx_reg, phase_reg);

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        phase_next     = phase_reg;
        eol_next       = eol_reg;
        eof_next       = eof_reg;
        rx_next        = rx_reg;
        gx_next        = gx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        column_next    = column_reg;
        row_out_next   = row_out_reg;
        eol_out_next   = eol_out_reg;
        eof_out_next   = eof_out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    col_next   = item.col;
                    row_next   = item.row;
                    phase_next = item.phase;
                    eol_next   = item.eol;
                    eof_next   = item.eof;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!busy_x && !busy_y)
                begin
                    rx_next    = gtp_pkg::mod255(gtp_pkg::MOD_IN_W'(quot_x));
                    gx_next    = gtp_pkg::mod255(gtp_pkg::MOD_IN_W'(quot_y));
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // load output register once the previous pixel is gone
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    red_next       = gtp_pkg::add_mod255(rx_reg,
                                         8'(gtp_pkg::COLOR_MOD) - phase_reg);
                    green_next     = green_val;
                    blue_next      = 8'(gtp_pkg::COLOR_MOD) - green_val;
                    column_next    = col_reg;
                    row_out_next   = row_reg;
                    eol_out_next   = eol_reg;
                    eof_out_next   = eof_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            phase_reg     <= '0;
            eol_reg       <= 1'b0;
            eof_reg       <= 1'b0;
            rx_reg        <= '0;
            gx_reg        <= '0;
            out_valid_reg <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            column_reg    <= '0;
            row_out_reg   <= '0;
            eol_out_reg   <= 1'b0;
            eof_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            phase_reg     <= phase_next;
            eol_reg       <= eol_next;
            eof_reg       <= eof_next;
            rx_reg        <= rx_next;
            gx_reg        <= gx_next;
            out_valid_reg <= out_valid_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            column_reg    <= column_next;
            row_out_reg   <= row_out_next;
            eol_out_reg   <= eol_out_next;
            eof_out_reg   <= eof_out_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign column       = column_reg;
    assign row          = row_out_reg;
    assign end_of_line  = eol_out_reg;
    assign end_of_frame = eof_out_reg;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int CB = gtp_pkg::COORD_BITS_DEF;
    localparam int unsigned RING = gtp_pkg::COLOR_MOD;
    // room for two pixels through the dividers plus queue slack
    localparam int SETTLE_CYCLES = 2 * (CB + 11) + 16;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
        logic [CB-1:0] column;
        logic [CB-1:0] row;
        logic          eol;
        logic          eof;
    } pixel_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic          pixel_request;
    logic          out_valid;
    logic          out_ready;
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
    logic [CB-1:0] column;
    logic [CB-1:0] row;
    logic          end_of_line;
    logic          end_of_frame;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [gtp_pkg::APB_ADDR_W-1:0] paddr;
    logic [gtp_pkg::APB_DATA_W-1:0] pwdata;
    logic [gtp_pkg::APB_DATA_W-1:0] prdata;
    logic          pready;

    // shadow of the generator state
    logic [CB-1:0] img_width;
    logic [CB-1:0] img_height;
    logic [CB-1:0] col_count;
    logic [CB-1:0] row_count;
    logic [7:0]    phase;

    pixel_t pending_pixels[$];

    // traffic shaping knobs
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    bit valid_up;

    // bookkeeping
    int fail_count;
    int pixels_checked;
    int frames_seen;
    int reg_writes;
    int input_stalls;

    gradient_test_pattern_gen #(
        .COORD_BITS(CB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pixel_request(pixel_request),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .red(red),
        .green(green),
        .blue(blue),
        .column(column),
        .row(row),
        .end_of_line(end_of_line),
        .end_of_frame(end_of_frame),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // next pixel of the raster, advancing the shadow counters
    function automatic pixel_t predict_pixel();
        pixel_t p;
        int unsigned w;
        int unsigned h;
        int unsigned qx;
        int unsigned qy;
        int unsigned g;
        w = (img_width == '0) ? 1 : 32'(img_width);
        h = (img_height == '0) ? 1 : 32'(img_height);
        qx = (32'(col_count) * RING) / w;
        qy = (32'(row_count) * RING) / h;
        g = (32'(phase) + qy) % RING;
        p.red = 8'((RING - 32'(phase) + qx) % RING);
        p.green = 8'(g);
        p.blue = 8'(RING - g);
        p.column = col_count;
        p.row = row_count;
        p.eol = (32'(col_count) + 1 >= w);
        p.eof = p.eol && (32'(row_count) + 1 >= h);
        if (p.eol)
        begin
            col_count = '0;
            if (p.eof)
            begin
                row_count = '0;
                phase = 8'((32'(phase) + 1) % RING);
            end
            else
            begin
                row_count = row_count + 1'b1;
            end
        end
        else
        begin
            col_count = col_count + 1'b1;
        end
        return p;
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("tb: mismatch at %0t: %s", $realtime, what);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned expd,
                                        input int unsigned got);
        if (expd != got)
        begin
            note_failure($sformatf("pixel %0d %s expected %0d got %0d",
                                   pixels_checked, name, expd, got));
        end
    endfunction

    function automatic void check_pixel();
        pixel_t e;
        if (pending_pixels.size() == 0)
        begin
            note_failure($sformatf("unexpected pixel col %0d row %0d", column, row));
            return;
        end
        e = pending_pixels.pop_front();
        check_field("red", e.red, red);
        check_field("green", e.green, green);
        check_field("blue", e.blue, blue);
        check_field("column", e.column, column);
        check_field("row", e.row, row);
        check_field("end_of_line", e.eol, end_of_line);
        check_field("end_of_frame", e.eof, end_of_frame);
        if (e.eof)
        begin
            frames_seen++;
        end
        pixels_checked++;
    endfunction

    // output side: check each transfer, then pick ready for the next cycle
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                check_pixel();
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // offer one request, wait for the transfer, then maybe go idle a while
    task automatic send_item(input logic req);
        in_valid <= 1'b1;
        pixel_request <= req;
        valid_up = 1'b1;
        do
        begin
            @(posedge clk);
            if (!in_ready)
            begin
                input_stalls++;
            end
        end
        while (!in_ready);
        if (req)
        begin
            pending_pixels.push_back(predict_pixel());
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            pixel_request <= 1'($urandom);
            valid_up = 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // send n pixel requests with a sprinkle of empty requests in between
    task automatic send_requests(input int n, input int empty_pct);
        int sent;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99) < empty_pct)
            begin
                send_item(1'b0);
            end
            else
            begin
                send_item(1'b1);
                sent++;
            end
        end
    endtask

    // stop offering, let every pixel come out and the pipeline go quiet
    task automatic settle();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input gtp_pkg::reg_idx_t idx, input logic [CB-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        // junk above the register width must be dropped
        pwdata <= ($urandom & ~32'((1 << CB) - 1)) | 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == gtp_pkg::REG_IMAGE_WIDTH)
        begin
            img_width = value;
        end
        else
        begin
            img_height = value;
        end
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic apb_check(input gtp_pkg::reg_idx_t idx);
        logic [CB-1:0] expd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        expd = (idx == gtp_pkg::REG_IMAGE_WIDTH) ? img_width : img_height;
        if (prdata != 32'(expd))
        begin
            note_failure($sformatf("register %s read expected %0d got %0d",
                                   idx.name(), expd, prdata));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input logic [CB-1:0] w, input logic [CB-1:0] h);
        apb_write(gtp_pkg::REG_IMAGE_WIDTH, w);
        apb_write(gtp_pkg::REG_IMAGE_HEIGHT, h);
        apb_check(gtp_pkg::REG_IMAGE_WIDTH);
        apb_check(gtp_pkg::REG_IMAGE_HEIGHT);
    endtask

    // mostly tiny frames so lines and frames wrap often, now and then the extremes
    function automatic logic [CB-1:0] pick_size(input int small_max);
        int r;
        r = $urandom_range(99);
        if (r < 6)
        begin
            return '0;
        end
        if (r < 12)
        begin
            return '1;
        end
        if (r < 20)
        begin
            return CB'($urandom_range(2 ** CB - 1, 1));
        end
        return CB'($urandom_range(small_max, 1));
    endfunction

    // registers out of reset, first pixels at the default size
    task automatic test_reset_state();
        apb_check(gtp_pkg::REG_IMAGE_WIDTH);
        apb_check(gtp_pkg::REG_IMAGE_HEIGHT);
        send_item(1'b1);
        send_item(1'b0);
        send_requests(3, 0);
        settle();
    endtask

    // zero size registers act as one; 1x2 frames
    task automatic test_tiny_frames();
        set_size('0, '0);
        send_requests(3, 0);
        settle();
        set_size(CB'(1), CB'(2));
        send_requests(3, 0);
        settle();
    endtask

    // shrink the size while a counter sits beyond the new last position
    task automatic test_shrink_mid_frame();
        set_size('1, '1);
        send_requests(6, 0);
        settle();
        set_size(CB'(3), '1);
        send_requests(1, 0);
        settle();
        set_size(CB'(1), '1);
        send_requests(3, 0);
        settle();
        set_size(CB'(1), CB'(2));
        send_item(1'b0);
        send_requests(2, 0);
        settle();
    endtask

    // one-pixel frames so the phase runs all the way round and wraps
    task automatic test_phase_wrap();
        send_idle_pct = 23;
        recv_stall_pct = 23;
        set_size('0, CB'(1));
        send_requests(260, 5);
        settle();
    endtask

    // output held off for a long stretch while requests keep coming
    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_size(CB'(5), CB'(3));
        hold_left = 400;
        send_requests(40, 0);
        settle();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (2)
        begin
            set_size(pick_size(12), pick_size(6));
            send_requests(20, 8);
            settle();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel_request = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        valid_up = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        fail_count = 0;
        pixels_checked = 0;
        frames_seen = 0;
        reg_writes = 0;
        input_stalls = 0;
        img_width = CB'(gtp_pkg::WIDTH_RESET);
        img_height = CB'(gtp_pkg::HEIGHT_RESET);
        col_count = '0;
        row_count = '0;
        phase = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_tiny_frames();
        test_shrink_mid_frame();
        test_random_traffic(0, 0);
        test_random_traffic(76, 0);
        test_random_traffic(0, 76);
        test_random_traffic(23, 23);
        test_phase_wrap();
        test_output_hold();
        settle();

        $display("tb: %0d pixels checked, %0d frames ended, %0d register writes",
                 pixels_checked, frames_seen, reg_writes);
        $display("tb: sizes 0..4095, mid-frame shrink, phase now %0d, %0d input stall cycles",
                 phase, input_stalls);
        if (fail_count == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
